### sv/tcw_pkg.sv
// Package for the text console writer: codes, defaults, command/status structs
// and the high-half glyph translation table. No dependencies.
package tcw_pkg;

	localparam int COLUMNS_DEFAULT = 80;
	localparam int ROWS_DEFAULT    = 25;

	localparam int PADDR_W = 3;
	localparam logic REG_ATTRIBUTE = 1'b0;
	localparam logic [7:0] ATTR_RESET = 8'h1F;

	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam int TAB_STEP = 4;

	typedef struct packed {
		logic load;
		logic put;
		logic read_req;
		logic read_cap;
		logic scroll_step;
		logic scroll_end;
		logic clear_step;
		logic clear_end;
	} tcw_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       need_scroll;
		logic       scroll_last;
		logic       clear_last;
	} tcw_status_t;

	localparam logic [7:0] HIGH_GLYPHS [128] = '{
		8'd0,   8'd0,   8'd0,   8'd159, 8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd173, 8'd155, 8'd156, 8'd0,   8'd157, 8'd124, 8'd22,
		8'd0,   8'd0,   8'd166, 8'd174, 8'd170, 8'd0,   8'd0,   8'd0,
		8'd248, 8'd241, 8'd254, 8'd0,   8'd0,   8'd230, 8'd0,   8'd249,
		8'd0,   8'd0,   8'd167, 8'd175, 8'd172, 8'd171, 8'd0,   8'd168,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd142, 8'd143, 8'd146, 8'd128,
		8'd0,   8'd144, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd165, 8'd0,   8'd0,   8'd0,   8'd0,   8'd153, 8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd154, 8'd0,   8'd0,   8'd0,
		8'd133, 8'd160, 8'd131, 8'd0,   8'd132, 8'd134, 8'd0,   8'd135,
		8'd138, 8'd130, 8'd136, 8'd137, 8'd141, 8'd161, 8'd140, 8'd139,
		8'd0,   8'd164, 8'd149, 8'd162, 8'd147, 8'd0,   8'd148, 8'd246,
		8'd237, 8'd151, 8'd163, 8'd150, 8'd129, 8'd0,   8'd0,   8'd152
	};

	function automatic logic [7:0] translate(input logic [7:0] code);
		logic [7:0] glyph;
		glyph = 8'd0;
		if (code[7]) begin
			glyph = HIGH_GLYPHS[code[6:0]];
		end else if (code >= CH_SPACE && code <= CH_TILDE) begin
			glyph = code;
		end
		return glyph;
	endfunction

endpackage

### sv/text_console_writer.sv
// Top level of the text console writer: APB attribute register, controller and
// datapath. Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// A command word is taken when start is high and busy is low. Its result word
// appears for one cycle with done high and must be taken then; there is no way
// to hold it off. A put of an ordinary character, a control code or a read
// passes through accept, execute, cursor check or read wait, and result
// before the next word is accepted. A put that runs past the last cell also
// scrolls, moving the screen store one cell per cycle through its single read
// and single write port. A clear writes one blank cell per cycle. The screen
// store is not cleared by reset; its contents are undefined until the first
// clear.
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 action,
	input  logic [7:0]                 char_code,
	input  logic [10:0]                cell_address,
	output logic                       done,
	output logic [10:0]                cursor_position,
	output logic [15:0]                cell_data,
	output logic                       scrolled,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tcw_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;

	logic        [7:0] attribute_q;
	tcw_cmd_t          cmd;
	tcw_status_t       status;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attribute_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ATTRIBUTE) begin
			attribute_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_ATTRIBUTE) ? {24'h000000, attribute_q} : 32'h0;

	tcw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.status(status),
		.cmd   (cmd)
	);

	tcw_datapath #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.attribute      (attribute_q),
		.action         (action),
		.char_code      (char_code),
		.cell_address   (cell_address),
		.cursor_position(cursor_position),
		.cell_data      (cell_data),
		.scrolled       (scrolled)
	);

	// The result strobe lasts one cycle and then frees the block.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted word did not make the block busy");

	// A scroll always leaves the cursor at the start of the last row.
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		done && scrolled |-> cursor_position == 11'(CELLS - COLUMNS))
		else $error("cursor not at last row start after scroll");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (CELLS > 2048) || (32'(cursor_position) < CELLS))
		else $error("cursor beyond the screen store");

endmodule

### sv/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg for the command and status structs and action codes.
module tcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	input  tcw_pkg::tcw_status_t status,
	output tcw_pkg::tcw_cmd_t    cmd
);
	import tcw_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_SCROLL = 3'd3;
	localparam logic [2:0] S_CLEAR  = 3'd4;
	localparam logic [2:0] S_RDWAIT = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (status.action)
					ACT_PUT: begin
						cmd.put = 1'b1;
						state_d = S_CHECK;
					end
					ACT_CLEAR: state_d = S_CLEAR;
					ACT_READ: begin
						cmd.read_req = 1'b1;
						state_d      = S_RDWAIT;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_CHECK: begin
				state_d = status.need_scroll ? S_SCROLL : S_DONE;
			end
			S_SCROLL: begin
				cmd.scroll_step = 1'b1;
				if (status.scroll_last) begin
					cmd.scroll_end = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_last) begin
					cmd.clear_end = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_RDWAIT: begin
				cmd.read_cap = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

### sv/tcw_datapath.sv
// Datapath of the text console writer: cursor registers, sweep counter, screen
// store and result registers. Depends on tcw_pkg and tcw_ram.
module tcw_datapath #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcw_pkg::tcw_cmd_t    cmd,
	output tcw_pkg::tcw_status_t status,
	input  logic [7:0]           attribute,
	input  logic [1:0]           action,
	input  logic [7:0]           char_code,
	input  logic [10:0]          cell_address,
	output logic [10:0]          cursor_position,
	output logic [15:0]          cell_data,
	output logic                 scrolled
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + COLUMNS + 1);
	localparam int KW    = $clog2(CELLS + 1);
	localparam int COLW  = $clog2(COLUMNS);

	logic [1:0]      action_q;
	logic [7:0]      code_q;
	logic [10:0]     addr_q;
	logic [CW-1:0]   cursor_q, cursor_d;
	logic [CW-1:0]   row_q, row_d;
	logic [COLW-1:0] col_q, col_d;
	logic [KW-1:0]   cnt_q;
	logic            rd_ok_q;
	logic [15:0]     cell_data_q;
	logic            scrolled_q;

	logic            we;
	logic [AW-1:0]   waddr;
	logic [15:0]     wdata;
	logic [AW-1:0]   raddr;
	logic [15:0]     rdata;
	logic [15:0]     blank;
	logic [2:0]      tab_delta;
	logic [COLW:0]   col_sum;

	assign blank = {attribute, CH_SPACE};

	// Row start and column are kept next to the cursor so that carriage return
	// and line feed need no division by the column count.
	always_comb begin
		cursor_d  = cursor_q;
		row_d     = row_q;
		col_d     = col_q;
		we        = 1'b0;
		waddr     = AW'(cursor_q);
		wdata     = blank;
		raddr     = '0;
		tab_delta = 3'(TAB_STEP) - {1'b0, cursor_q[1:0]};
		col_sum   = {1'b0, col_q} + (COLW + 1)'(tab_delta);

		if (cmd.put) begin
			priority if (code_q == CH_BS && cursor_q != '0) begin
				cursor_d = cursor_q - 1'b1;
				we       = 1'b1;
				waddr    = AW'(cursor_q - 1'b1);
				if (col_q == '0) begin
					col_d = COLW'(COLUMNS - 1);
					row_d = row_q - CW'(COLUMNS);
				end else begin
					col_d = col_q - 1'b1;
				end
			end else if (code_q == CH_TAB) begin
				cursor_d = cursor_q + CW'(tab_delta);
				if (32'(col_sum) >= COLUMNS) begin
					col_d = COLW'(32'(col_sum) - COLUMNS);
					row_d = row_q + CW'(COLUMNS);
				end else begin
					col_d = COLW'(col_sum);
				end
			end else if (code_q == CH_CR) begin
				cursor_d = row_q;
				col_d    = '0;
			end else if (code_q == CH_LF) begin
				cursor_d = row_q + CW'(COLUMNS);
				row_d    = row_q + CW'(COLUMNS);
				col_d    = '0;
			end else if (code_q >= CH_SPACE) begin
				cursor_d = cursor_q + 1'b1;
				we       = 1'b1;
				wdata    = {attribute, translate(code_q)};
				if (32'(col_q) == COLUMNS - 1) begin
					col_d = '0;
					row_d = row_q + CW'(COLUMNS);
				end else begin
					col_d = col_q + 1'b1;
				end
			end else begin
				cursor_d = cursor_q;
			end
		end

		if (cmd.read_req) begin
			raddr = AW'(addr_q);
		end

		// The scroll copy reads one row ahead and writes the word read in the
		// previous cycle, then fills the last row with blanks.
		if (cmd.scroll_step) begin
			if (32'(cnt_q) < CELLS - COLUMNS) begin
				raddr = AW'(32'(cnt_q) + COLUMNS);
			end
			if (cnt_q != '0) begin
				we    = 1'b1;
				waddr = AW'(cnt_q - 1'b1);
				wdata = (32'(cnt_q) <= CELLS - COLUMNS) ? rdata : blank;
			end
		end

		if (cmd.clear_step) begin
			we    = 1'b1;
			waddr = AW'(cnt_q);
			wdata = blank;
		end

		if (cmd.scroll_end) begin
			cursor_d = CW'(CELLS - COLUMNS);
			row_d    = CW'(CELLS - COLUMNS);
			col_d    = '0;
		end

		if (cmd.clear_end) begin
			cursor_d = '0;
			row_d    = '0;
			col_d    = '0;
		end
	end

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			code_q   <= char_code;
			addr_q   <= cell_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			row_q       <= '0;
			col_q       <= '0;
			cnt_q       <= '0;
			rd_ok_q     <= 1'b0;
			cell_data_q <= '0;
			scrolled_q  <= 1'b0;
		end else begin
			cursor_q <= cursor_d;
			row_q    <= row_d;
			col_q    <= col_d;
			if (cmd.load) begin
				cnt_q       <= '0;
				cell_data_q <= '0;
				scrolled_q  <= 1'b0;
			end else if (cmd.scroll_step || cmd.clear_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.read_req) begin
				rd_ok_q <= (32'(addr_q) < CELLS);
			end
			if (cmd.read_cap) begin
				cell_data_q <= rd_ok_q ? rdata : 16'h0000;
			end
			if (cmd.scroll_end) begin
				scrolled_q <= 1'b1;
			end
		end
	end

	assign status.action      = action_q;
	assign status.need_scroll = (32'(cursor_q) >= CELLS);
	assign status.scroll_last = (32'(cnt_q) == CELLS);
	assign status.clear_last  = (32'(cnt_q) == CELLS - 1);

	assign cursor_position = 11'(cursor_q);
	assign cell_data       = cell_data_q;
	assign scrolled        = scrolled_q;

endmodule

### dv/tb.sv
// Self-checking testbench for text_console_writer: command words in, result words out,
// checked against an internal model of the screen store and cursor.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 1ps

module tb;
	import tcw_pkg::*;

	localparam int COLS  = COLUMNS_DEFAULT;
	localparam int LINES = ROWS_DEFAULT;
	localparam int CELLS = COLS * LINES;
	localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'(4 * int'(REG_ATTRIBUTE));

	// Code-page glyphs for bytes 0x80..0xFF.
	localparam logic [7:0] UPPER_GLYPHS [128] = '{
		8'd0,   8'd0,   8'd0,   8'd159, 8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd173, 8'd155, 8'd156, 8'd0,   8'd157, 8'd124, 8'd22,
		8'd0,   8'd0,   8'd166, 8'd174, 8'd170, 8'd0,   8'd0,   8'd0,
		8'd248, 8'd241, 8'd254, 8'd0,   8'd0,   8'd230, 8'd0,   8'd249,
		8'd0,   8'd0,   8'd167, 8'd175, 8'd172, 8'd171, 8'd0,   8'd168,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd142, 8'd143, 8'd146, 8'd128,
		8'd0,   8'd144, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd165, 8'd0,   8'd0,   8'd0,   8'd0,   8'd153, 8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd154, 8'd0,   8'd0,   8'd0,
		8'd133, 8'd160, 8'd131, 8'd0,   8'd132, 8'd134, 8'd0,   8'd135,
		8'd138, 8'd130, 8'd136, 8'd137, 8'd141, 8'd161, 8'd140, 8'd139,
		8'd0,   8'd164, 8'd149, 8'd162, 8'd147, 8'd0,   8'd148, 8'd246,
		8'd237, 8'd151, 8'd163, 8'd150, 8'd129, 8'd0,   8'd0,   8'd152
	};

	typedef struct packed {
		logic [1:0]  act;
		logic [7:0]  code;
		logic [10:0] addr;
	} console_word_t;

	typedef struct packed {
		logic [10:0] cursor;
		logic [15:0] data;
		logic        scrolled;
	} console_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  action = ACT_PUT;
	logic [7:0]  char_code = 8'h00;
	logic [10:0] cell_address = 11'd0;
	logic        done;
	logic [10:0] cursor_position;
	logic [15:0] cell_data;
	logic        scrolled;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	console_word_t   pending_words [$];
	console_result_t expected_results [$];
	console_word_t   next_word;
	console_result_t oldest_result;
	int              words_taken = 0;
	int              error_count = 0;

	// Model of the screen store, cursor and attribute register.
	logic [15:0] screen_model [CELLS];
	int          cursor_model = 0;
	logic [7:0]  attr_model = ATTR_RESET;

	text_console_writer DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .char_code(char_code), .cell_address(cell_address),
		.done(done), .cursor_position(cursor_position), .cell_data(cell_data),
		.scrolled(scrolled), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	function automatic console_result_t apply_word(input logic [1:0] act,
		input logic [7:0] code, input logic [10:0] addr);
		console_result_t res;
		logic [7:0]      glyph;
		logic [15:0]     blank;
		res = '0;
		blank = {attr_model, CH_SPACE};
		unique case (act)
			ACT_PUT: begin
				if (code == CH_BS) begin
					if (cursor_model > 0) begin
						cursor_model--;
						screen_model[cursor_model] = blank;
					end
				end else if (code == CH_TAB) begin
					cursor_model = (cursor_model + TAB_STEP) & ~(TAB_STEP - 1);
				end else if (code == CH_CR) begin
					cursor_model = (cursor_model / COLS) * COLS;
				end else if (code == CH_LF) begin
					cursor_model = ((cursor_model + COLS) / COLS) * COLS;
				end else if (code >= CH_SPACE) begin
					if (code[7]) begin
						glyph = UPPER_GLYPHS[code[6:0]];
					end else begin
						glyph = (code <= CH_TILDE) ? code : 8'h00;
					end
					screen_model[cursor_model] = {attr_model, glyph};
					cursor_model++;
				end
				// Running off the end moves every row up and blanks the last one.
				if (cursor_model >= CELLS) begin
					for (int i = 0; i < CELLS - COLS; i++) begin
						screen_model[i] = screen_model[i + COLS];
					end
					for (int i = CELLS - COLS; i < CELLS; i++) begin
						screen_model[i] = blank;
					end
					cursor_model = CELLS - COLS;
					res.scrolled = 1'b1;
				end
			end
			ACT_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					screen_model[i] = blank;
				end
				cursor_model = 0;
			end
			ACT_READ: begin
				if (addr < CELLS) begin
					res.data = screen_model[addr];
				end
			end
			default: begin
			end
		endcase
		res.cursor = cursor_model[10:0];
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < 10) begin
			$display("%0t: %s", $realtime, msg);
		end
		error_count++;
	endtask

	task automatic add_word(input logic [1:0] act, input logic [7:0] code,
		input logic [10:0] addr);
		console_word_t w;
		w.act = act;
		w.code = code;
		w.addr = addr;
		pending_words.push_back(w);
	endtask

	task automatic add_put(input logic [7:0] code);
		add_word(ACT_PUT, code, 11'($urandom_range(2047)));
	endtask

	task automatic add_read(input logic [10:0] addr);
		add_word(ACT_READ, 8'($urandom_range(255)), addr);
	endtask

	task automatic check_attribute(input logic [7:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ATTR_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== want) begin
			report_mismatch($sformatf("attribute readback: expected %h, got %h",
				want, prdata[7:0]));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_attribute(input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ATTR_ADDR;
		pwdata <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		attr_model = value;
		check_attribute(value);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_words.size() != 0 || expected_results.size() != 0 || start || busy)
			@(negedge clk);
	endtask

	task automatic queue_directed();
		add_word(ACT_CLEAR, 8'hA5, 11'd1234);
		add_read(11'd0);
		add_put(CH_BS);
		add_put(8'h41);
		add_put(CH_SPACE);
		add_put(CH_TILDE);
		add_put(8'h7F);
		add_put(8'h80);
		add_put(8'h83);
		add_put(8'hFF);
		add_put(CH_TAB);
		add_put(CH_BS);
		add_put(CH_CR);
		add_put(CH_LF);
		add_put(8'h00);
		add_put(8'h1F);
		add_word(2'd3, 8'hFF, 11'd2047);
		add_read(11'd1999);
		add_read(11'd2000);
		add_read(11'd2047);
		add_read(11'd1);
		add_read(11'd4);
		add_read(11'd0);
	endtask

	// Mostly lines of text with line endings, plus reads, clears and some noise.
	task automatic queue_random(input int count);
		int target;
		int pick;
		int len;
		int r;
		target = pending_words.size() + count;
		while (pending_words.size() < target) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(12);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(99);
					if (r < 75) add_put(8'($urandom_range(32, 126)));
					else if (r < 90) add_put(8'($urandom_range(128, 255)));
					else if (r < 95) add_put(CH_TAB);
					else add_put(CH_BS);
				end
				r = $urandom_range(2);
				if (r == 1) add_put(CH_CR);
				if (r != 2) add_put(CH_LF);
			end else if (pick < 60) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
				for (int i = 0; i < len; i++) add_put(CH_LF);
			end else if (pick < 80) begin
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(19) == 0) add_read(11'($urandom_range(2000, 2047)));
					else add_read(11'($urandom_range(CELLS - 1)));
				end
			end else if (pick < 88) begin
				add_put(8'($urandom_range(255)));
			end else if (pick < 92) begin
				add_word(2'd3, 8'($urandom_range(255)), 11'($urandom_range(2047)));
			end else if (pick < 95) begin
				add_word(ACT_CLEAR, 8'($urandom_range(255)), 11'($urandom_range(2047)));
			end else begin
				len = $urandom_range(1, 5);
				for (int i = 0; i < len; i++) add_put(CH_BS);
			end
		end
	endtask

	// Driver: holds a word while busy, takes the next one after each accept.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			action <= ACT_PUT;
			char_code <= 8'h00;
			cell_address <= 11'd0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(apply_word(action, char_code, cell_address));
				words_taken++;
			end
			if (!start || !busy) begin
				if (pending_words.size() != 0 &&
					((words_taken >= 250 && words_taken < 400) || $urandom_range(99) >= 23)) begin
					next_word = pending_words.pop_front();
					start <= 1'b1;
					action <= next_word.act;
					char_code <= next_word.code;
					cell_address <= next_word.addr;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done cycle carries one result word.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result: cursor %0d data %h scrolled %0b",
					cursor_position, cell_data, scrolled));
			end else begin
				oldest_result = expected_results.pop_front();
				if (cursor_position !== oldest_result.cursor ||
					cell_data !== oldest_result.data ||
					scrolled !== oldest_result.scrolled) begin
					report_mismatch($sformatf(
						"expected cursor %0d data %h scrolled %0b, got cursor %0d data %h scrolled %0b",
						oldest_result.cursor, oldest_result.data, oldest_result.scrolled,
						cursor_position, cell_data, scrolled));
				end
			end
		end
	end

	initial begin
		#(64'd200_000_000);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		for (int i = 0; i < CELLS; i++) screen_model[i] = 16'h0000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		check_attribute(ATTR_RESET);
		queue_directed();
		wait_idle();
		write_attribute(8'h00);
		queue_random(150);
		wait_idle();
		write_attribute(8'hFF);
		queue_random(150);
		wait_idle();
		write_attribute(8'($urandom_range(1, 254)));
		queue_random(150);
		wait_idle();
		write_attribute(8'($urandom_range(255)));
		queue_random(150);
		wait_idle();
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### text_console_writer.f
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_ctrl.sv
sv/tcw_datapath.sv
sv/text_console_writer.sv
dv/tb.sv
